FILE: design/kalc_pkg.sv
// Shared types and constants for the knob activity level classifier.
// Holds the item format passed from the front end to the back end and the
// piecewise linearization tables. No dependencies.
package kalc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int DATA_BITS   = 16;
    localparam int INDEX_BITS  = 3;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int SLOPE_W  = 10;
    localparam int OFFSET_W = SAMPLE_BITS;
    localparam int PROD_W   = OFFSET_W + SLOPE_W;
    localparam int RECIP_SH = 33;
    localparam int RECIP_W  = 26;
    localparam int QUOT_W   = PROD_W + RECIP_W - RECIP_SH;

    localparam logic [DATA_BITS-1:0] WINDOW_RESET = 16'd1000;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_DELTA_THRESHOLD       = 3'd0,
        REG_LIMIT_SELF_REGULATING = 3'd1,
        REG_LIMIT_ACTIVE          = 3'd2,
        REG_LIMIT_OVERWHELMED     = 3'd3,
        REG_WINDOW_LENGTH_MS      = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        LEVEL_CALM           = 2'd0,
        LEVEL_SELF_REGULATING = 2'd1,
        LEVEL_ACTIVE         = 2'd2,
        LEVEL_OVERWHELMED    = 2'd3
    } level_t;

    typedef enum logic [2:0] {
        SEG_0 = 3'd0,
        SEG_1 = 3'd1,
        SEG_2 = 3'd2,
        SEG_3 = 3'd3,
        SEG_4 = 3'd4,
        SEG_5 = 3'd5
    } seg_t;

    typedef struct packed {
        logic                   tick;
        logic [SAMPLE_BITS-1:0] linear;
    } kalc_item_t;

    localparam logic [63:0] ONE_SHIFTED = 64'd1 << RECIP_SH;
    localparam logic [RECIP_W-1:0] RECIP_0 = RECIP_W'((ONE_SHIFTED + 64'd199) / 64'd200);
    localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'((ONE_SHIFTED + 64'd138) / 64'd139);
    localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((ONE_SHIFTED + 64'd178) / 64'd179);
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((ONE_SHIFTED + 64'd318) / 64'd319);
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((ONE_SHIFTED + 64'd808) / 64'd809);
    localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((ONE_SHIFTED + 64'd2443) / 64'd2444);

    function automatic seg_t seg_of(input logic [SAMPLE_BITS-1:0] x);
        seg_t s;
        if (x <= 12'd200)
            s = SEG_0;
        else if (x <= 12'd340)
            s = SEG_1;
        else if (x <= 12'd520)
            s = SEG_2;
        else if (x <= 12'd840)
            s = SEG_3;
        else if (x <= 12'd1650)
            s = SEG_4;
        else
            s = SEG_5;
        return s;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] seg_in_lo(input seg_t s);
        logic [SAMPLE_BITS-1:0] v;
        unique case (s)
            SEG_0:   v = 12'd0;
            SEG_1:   v = 12'd201;
            SEG_2:   v = 12'd341;
            SEG_3:   v = 12'd521;
            SEG_4:   v = 12'd841;
            SEG_5:   v = 12'd1651;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

    function automatic logic [SLOPE_W-1:0] seg_slope(input seg_t s);
        logic [SLOPE_W-1:0] v;
        unique case (s)
            SEG_0:   v = 10'd682;
            SEG_1:   v = 10'd682;
            SEG_2:   v = 10'd681;
            SEG_3:   v = 10'd681;
            SEG_4:   v = 10'd682;
            SEG_5:   v = 10'd682;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

    function automatic logic [RECIP_W-1:0] seg_recip(input seg_t s);
        logic [RECIP_W-1:0] v;
        unique case (s)
            SEG_0:   v = RECIP_0;
            SEG_1:   v = RECIP_1;
            SEG_2:   v = RECIP_2;
            SEG_3:   v = RECIP_3;
            SEG_4:   v = RECIP_4;
            SEG_5:   v = RECIP_5;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] seg_out_lo(input seg_t s);
        logic [SAMPLE_BITS-1:0] v;
        unique case (s)
            SEG_0:   v = 12'd0;
            SEG_1:   v = 12'd683;
            SEG_2:   v = 12'd1366;
            SEG_3:   v = 12'd2048;
            SEG_4:   v = 12'd2730;
            SEG_5:   v = 12'd3413;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/kalc_front.sv
// Front end: accepts input transfers and linearizes samples in three stages.
// Holds the credit count that keeps the queue from overflowing.
// Depends on kalc_pkg.
module kalc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            command,
    input  logic [kalc_pkg::SAMPLE_BITS-1:0] sample_raw,
    input  logic                            pop,
    output logic                            push_valid,
    output kalc_pkg::kalc_item_t            push_item
);
    import kalc_pkg::*;

    logic [OCC_W-1:0]       occ_reg;
    logic [OCC_W-1:0]       occ_next;
    logic                   accept;

    logic                   s1_valid_reg;
    logic                   s1_tick_reg;
    seg_t                   s1_seg_reg;
    logic [OFFSET_W-1:0]    s1_offset_reg;

    logic                   s2_valid_reg;
    logic                   s2_tick_reg;
    seg_t                   s2_seg_reg;
    logic [PROD_W-1:0]      s2_prod_reg;

    logic                   s3_valid_reg;
    logic                   s3_tick_reg;
    logic [SAMPLE_BITS-1:0] s3_linear_reg;

    seg_t                   seg_in;
    logic [PROD_W+RECIP_W-1:0] scaled;
    logic [QUOT_W-1:0]      quotient;

    assign in_stall = (occ_reg >= OCC_W'(QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;
    assign occ_next = occ_reg + OCC_W'(accept) - OCC_W'(pop);

    assign seg_in   = seg_of(sample_raw);
    assign scaled   = (PROD_W + RECIP_W)'(s2_prod_reg) * (PROD_W + RECIP_W)'(seg_recip(s2_seg_reg));
    assign quotient = scaled[PROD_W+RECIP_W-1:RECIP_SH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tick_reg   <= command;
        s1_seg_reg    <= seg_in;
        s1_offset_reg <= sample_raw - seg_in_lo(seg_in);

        s2_tick_reg   <= s1_tick_reg;
        s2_seg_reg    <= s1_seg_reg;
        s2_prod_reg   <= PROD_W'(s1_offset_reg) * PROD_W'(seg_slope(s1_seg_reg));

        s3_tick_reg   <= s2_tick_reg;
        s3_linear_reg <= SAMPLE_BITS'(quotient) + seg_out_lo(s2_seg_reg);
    end

    assign push_valid       = s3_valid_reg;
    assign push_item.tick   = s3_tick_reg;
    assign push_item.linear = s3_linear_reg;

endmodule

FILE: design/kalc_queue.sv
// Short first-in first-out queue between the front end and the back end.
// Overflow is prevented by the front end's credit count.
// Depends on kalc_pkg.
module kalc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  kalc_pkg::kalc_item_t push_item,
    input  logic                 pop,
    output logic                 head_valid,
    output kalc_pkg::kalc_item_t head_item
);
    import kalc_pkg::*;

    kalc_item_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [OCC_W-1:0]       count_reg;

    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + OCC_W'(push_valid) - OCC_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: design/kalc_back.sv
// Back end: configuration registers, activity counting, window timing and
// grading, and the output register. Depends on kalc_pkg.
module kalc_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            write_enable,
    input  logic [kalc_pkg::INDEX_BITS-1:0] write_index,
    input  logic [kalc_pkg::DATA_BITS-1:0]  write_data,
    input  logic                            head_valid,
    input  kalc_pkg::kalc_item_t            head_item,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [kalc_pkg::SAMPLE_BITS-1:0] linear_value,
    output logic                            window_closed,
    output logic [1:0]                      level,
    output logic [kalc_pkg::DATA_BITS-1:0]  window_count
);
    import kalc_pkg::*;

    localparam int CMP_W = (COUNT_BITS > DATA_BITS) ? COUNT_BITS : DATA_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [CMP_W-1:0] REPORT_MAX = CMP_W'({DATA_BITS{1'b1}});

    logic [SAMPLE_BITS-1:0] thr_reg;
    logic [DATA_BITS-1:0]   lim_sr_reg;
    logic [DATA_BITS-1:0]   lim_act_reg;
    logic [DATA_BITS-1:0]   lim_ovw_reg;
    logic [DATA_BITS-1:0]   win_reg;

    logic [SAMPLE_BITS-1:0] prev_reg;
    logic [SAMPLE_BITS-1:0] prev_next;
    logic                   base_valid_reg;
    logic                   base_valid_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic [DATA_BITS-1:0]   elapsed_reg;
    logic [DATA_BITS-1:0]   elapsed_next;
    level_t                 level_reg;
    level_t                 level_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_BITS-1:0] out_linear_reg;
    logic                   out_closed_reg;
    level_t                 out_level_reg;
    logic [DATA_BITS-1:0]   out_count_reg;

    logic                   out_free;
    logic                   take_sample;
    logic                   take_tick;
    logic [SAMPLE_BITS-1:0] lin;
    logic [SAMPLE_BITS-1:0] base;
    logic [SAMPLE_BITS-1:0] diff;
    logic [COUNT_BITS-1:0]  count_upd;
    logic [CMP_W-1:0]       count_cmp;
    logic                   closed;
    level_t                 graded;
    logic [DATA_BITS-1:0]   reported;

    assign out_free    = !out_valid_reg || !out_stall;
    assign pop         = head_valid && (head_item.tick || out_free);
    assign take_sample = pop && !head_item.tick;
    assign take_tick   = pop && head_item.tick;

    assign lin  = head_item.linear;
    assign base = base_valid_reg ? prev_reg : lin;
    assign diff = (lin >= base) ? (lin - base) : (base - lin);

    assign count_upd = ((diff > thr_reg) && (count_reg != COUNT_MAX)) ?
                       count_reg + 1'b1 : count_reg;
    assign count_cmp = CMP_W'(count_upd);
    assign closed    = (elapsed_reg >= win_reg);
    assign reported  = (count_cmp > REPORT_MAX) ? DATA_BITS'(REPORT_MAX)
                                                : DATA_BITS'(count_cmp);

    always_comb
    begin
        if (count_cmp >= CMP_W'(lim_ovw_reg))
            graded = LEVEL_OVERWHELMED;
        else if (count_cmp >= CMP_W'(lim_act_reg))
            graded = LEVEL_ACTIVE;
        else if (count_cmp >= CMP_W'(lim_sr_reg))
            graded = LEVEL_SELF_REGULATING;
        else
            graded = LEVEL_CALM;
    end

    always_comb
    begin
        prev_next       = prev_reg;
        base_valid_next = base_valid_reg;
        count_next      = count_reg;
        elapsed_next    = elapsed_reg;
        level_next      = level_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (take_tick)
        begin
            if (elapsed_reg != {DATA_BITS{1'b1}})
                elapsed_next = elapsed_reg + 1'b1;
        end
        if (take_sample)
        begin
            prev_next       = lin;
            base_valid_next = 1'b1;
            out_valid_next  = 1'b1;
            if (closed)
            begin
                level_next   = graded;
                count_next   = '0;
                elapsed_next = '0;
            end
            else
            begin
                count_next = count_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= '0;
            lim_sr_reg     <= '0;
            lim_act_reg    <= '0;
            lim_ovw_reg    <= '0;
            win_reg        <= WINDOW_RESET;
            prev_reg       <= '0;
            base_valid_reg <= 1'b0;
            count_reg      <= '0;
            elapsed_reg    <= '0;
            level_reg      <= LEVEL_CALM;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (write_enable)
            begin
                unique case (write_index)
                    REG_DELTA_THRESHOLD:       thr_reg     <= write_data[SAMPLE_BITS-1:0];
                    REG_LIMIT_SELF_REGULATING: lim_sr_reg  <= write_data;
                    REG_LIMIT_ACTIVE:          lim_act_reg <= write_data;
                    REG_LIMIT_OVERWHELMED:     lim_ovw_reg <= write_data;
                    REG_WINDOW_LENGTH_MS:      win_reg     <= write_data;
                    default:                   ;
                endcase
            end
            prev_reg       <= prev_next;
            base_valid_reg <= base_valid_next;
            count_reg      <= count_next;
            elapsed_reg    <= elapsed_next;
            level_reg      <= level_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            out_linear_reg <= lin;
            out_closed_reg <= closed;
            out_level_reg  <= level_next;
            out_count_reg  <= reported;
        end
    end

    assign out_valid     = out_valid_reg;
    assign linear_value  = out_linear_reg;
    assign window_closed = out_closed_reg;
    assign level         = out_level_reg;
    assign window_count  = out_count_reg;

endmodule

FILE: design/knob_activity_level_classifier.sv
// Takes converter samples and millisecond ticks and grades knob activity
// per window into one of four levels. A new item is accepted every cycle
// while in_stall is low. A sample's result passes through the segment, slope
// multiply and reciprocal multiply stages of the linearizer, the queue entry
// and the output register, and an output stall can hold it there. The input
// stalls only when eight items are between the input and the back end.
// Ticks produce no result. Depends on kalc_pkg, kalc_front, kalc_queue and
// kalc_back.
module knob_activity_level_classifier #(
    parameter int COUNT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             write_enable,
    input  logic [kalc_pkg::INDEX_BITS-1:0]  write_index,
    input  logic [kalc_pkg::DATA_BITS-1:0]   write_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic [kalc_pkg::SAMPLE_BITS-1:0] sample_raw,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [kalc_pkg::SAMPLE_BITS-1:0] linear_value,
    output logic                             window_closed,
    output logic [1:0]                       level,
    output logic [kalc_pkg::DATA_BITS-1:0]   window_count
);
    import kalc_pkg::*;

    logic       push_valid;
    kalc_item_t push_item;
    logic       head_valid;
    kalc_item_t head_item;
    logic       pop;

    kalc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .sample_raw (sample_raw),
        .pop        (pop),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    kalc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    kalc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .write_enable  (write_enable),
        .write_index   (write_index),
        .write_data    (write_data),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .linear_value  (linear_value),
        .window_closed (window_closed),
        .level         (level),
        .window_count  (window_count)
    );

endmodule

FILE: test/tb_knob_activity_level_classifier.sv
`timescale 1ns / 100ps
// Self-checking testbench for knob_activity_level_classifier: directed and random samples
// and ticks are checked against an in-bench model of the linearizer and window grader.
// Depends on kalc_pkg and the design sources only.
module tb_knob_activity_level_classifier;
    import kalc_pkg::*;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned SPARE_INDEX   = int'(REG_WINDOW_LENGTH_MS) + 1;
    localparam logic [15:0] ALL_ONES_16   = 16'hFFFF;
    localparam logic [SAMPLE_BITS-1:0] SEGMENT_ENDS [12] = '{
        12'd0, 12'd200, 12'd201, 12'd340, 12'd341, 12'd520,
        12'd521, 12'd840, 12'd841, 12'd1650, 12'd1651, 12'd4095
    };

    typedef struct {
        logic                   cmd;
        logic [SAMPLE_BITS-1:0] raw;
        bit                     hold;
    } knob_item_t;

    typedef struct {
        logic [SAMPLE_BITS-1:0] linear;
        logic                   closed;
        level_t                 lvl;
        logic [DATA_BITS-1:0]   count;
    } reading_t;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   write_enable = 1'b0;
    logic [INDEX_BITS-1:0]  write_index  = '0;
    logic [DATA_BITS-1:0]   write_data   = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic                   command      = CMD_SAMPLE;
    logic [SAMPLE_BITS-1:0] sample_raw   = '0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic [SAMPLE_BITS-1:0] linear_value;
    logic                   window_closed;
    logic [1:0]             level;
    logic [DATA_BITS-1:0]   window_count;

    logic [SAMPLE_BITS-1:0] thr_cfg = '0;
    logic [15:0]            lim_sr  = '0;
    logic [15:0]            lim_act = '0;
    logic [15:0]            lim_ovr = '0;
    logic [15:0]            win_cfg = WINDOW_RESET;

    logic [SAMPLE_BITS-1:0] prev_linear   = '0;
    bit                     have_baseline = 1'b0;
    logic [15:0]            activity      = '0;
    logic [15:0]            elapsed       = '0;
    level_t                 level_now     = LEVEL_CALM;

    knob_item_t  pending_items[$];
    reading_t    expected_readings[$];

    int unsigned fault_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned samples_sent   = 0;
    int unsigned ticks_sent     = 0;
    int unsigned windows_closed = 0;
    int unsigned settings_used  = 1;
    int unsigned gap_left       = 0;
    int unsigned stall_left     = 0;
    logic [3:0]  levels_seen    = '0;
    bit          quiet          = 1'b1;
    logic [SAMPLE_BITS-1:0] last_raw = '0;

    knob_activity_level_classifier dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .write_enable  (write_enable),
        .write_index   (write_index),
        .write_data    (write_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .sample_raw    (sample_raw),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .linear_value  (linear_value),
        .window_closed (window_closed),
        .level         (level),
        .window_count  (window_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [SAMPLE_BITS-1:0] knob_linear(input logic [SAMPLE_BITS-1:0] x);
        int unsigned in_lo, in_hi, out_lo, out_hi, v;
        if (x <= 12'd200)
        begin
            in_lo = 0; in_hi = 200; out_lo = 0; out_hi = 682;
        end
        else if (x <= 12'd340)
        begin
            in_lo = 201; in_hi = 340; out_lo = 683; out_hi = 1365;
        end
        else if (x <= 12'd520)
        begin
            in_lo = 341; in_hi = 520; out_lo = 1366; out_hi = 2047;
        end
        else if (x <= 12'd840)
        begin
            in_lo = 521; in_hi = 840; out_lo = 2048; out_hi = 2729;
        end
        else if (x <= 12'd1650)
        begin
            in_lo = 841; in_hi = 1650; out_lo = 2730; out_hi = 3412;
        end
        else
        begin
            in_lo = 1651; in_hi = 4095; out_lo = 3413; out_hi = 4095;
        end
        v = (32'(x) - in_lo) * (out_hi - out_lo) / (in_hi - in_lo) + out_lo;
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic level_t grade_count(input logic [15:0] c);
        if (c >= lim_ovr)
            return LEVEL_OVERWHELMED;
        if (c >= lim_act)
            return LEVEL_ACTIVE;
        if (c >= lim_sr)
            return LEVEL_SELF_REGULATING;
        return LEVEL_CALM;
    endfunction

    task automatic classify_item(input logic cmd, input logic [SAMPLE_BITS-1:0] raw);
        logic [SAMPLE_BITS-1:0] lin, diff;
        reading_t r;
        if (cmd == CMD_TICK)
        begin
            ticks_sent++;
            if (elapsed != ALL_ONES_16)
                elapsed = elapsed + 1'b1;
            return;
        end
        lin = knob_linear(raw);
        if (!have_baseline)
        begin
            prev_linear = lin;
            have_baseline = 1'b1;
        end
        diff = (lin >= prev_linear) ? lin - prev_linear : prev_linear - lin;
        if (diff > thr_cfg && activity != ALL_ONES_16)
            activity = activity + 1'b1;
        prev_linear = lin;
        r.linear = lin;
        r.closed = 1'b0;
        r.count = activity;
        if (elapsed >= win_cfg)
        begin
            r.closed = 1'b1;
            level_now = grade_count(activity);
            activity = '0;
            elapsed = '0;
        end
        r.lvl = level_now;
        expected_readings.push_back(r);
        samples_sent++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A held item is not offered until every outstanding result has been seen.
    always @(posedge clk)
    begin : drive_items
        knob_item_t nxt;
        logic valid_next;
        valid_next = in_valid;
        if (in_valid && !in_stall)
        begin
            classify_item(command, sample_raw);
            valid_next = 1'b0;
        end
        if (rst_n && !valid_next)
        begin
            if (gap_left != 0)
                gap_left--;
            else if (pending_items.size() != 0 &&
                     !(pending_items[0].hold && expected_readings.size() != 0))
            begin
                nxt = pending_items.pop_front();
                command <= nxt.cmd;
                sample_raw <= nxt.raw;
                valid_next = 1'b1;
                gap_left = quiet ? 0 : pick_gap();
            end
        end
        in_valid <= valid_next;
    end

    always @(posedge clk)
    begin : watch_results
        reading_t want;
        logic stall_next;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                if (fault_count < REPORT_LIMIT)
                    $display("Cycle %0d: unexpected result lin %0d closed %0b level %0d count %0d",
                             cycle_count, linear_value, window_closed, level, window_count);
                fault_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (want.closed)
                    windows_closed++;
                levels_seen[want.lvl] = 1'b1;
                if (linear_value !== want.linear || window_closed !== want.closed ||
                    level !== want.lvl || window_count !== want.count)
                begin
                    if (fault_count < REPORT_LIMIT)
                        $display("Cycle %0d: expected %0d/%0b/%0d/%0d, got %0d/%0b/%0d/%0d",
                                 cycle_count, want.linear, want.closed, want.lvl, want.count,
                                 linear_value, window_closed, level, window_count);
                    fault_count++;
                end
            end
        end
        if (!rst_n || quiet)
        begin
            stall_left = 0;
            stall_next = 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            stall_next = 1'b1;
        end
        else if ($urandom_range(0, 99) < 20)
        begin
            stall_left = pick_gap();
            stall_next = 1'b1;
        end
        else
            stall_next = 1'b0;
        out_stall <= stall_next;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, expected_readings.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic set_register(input logic [INDEX_BITS-1:0] idx,
                                input logic [DATA_BITS-1:0] data);
        @(posedge clk);
        write_enable <= 1'b1;
        write_index <= idx;
        write_data <= data;
        case (idx)
            REG_DELTA_THRESHOLD:       thr_cfg = data[SAMPLE_BITS-1:0];
            REG_LIMIT_SELF_REGULATING: lim_sr = data;
            REG_LIMIT_ACTIVE:          lim_act = data;
            REG_LIMIT_OVERWHELMED:     lim_ovr = data;
            REG_WINDOW_LENGTH_MS:      win_cfg = data;
            default: ;
        endcase
    endtask

    // Writes to the unused indices go first and must leave every setting alone.
    task automatic configure(input logic [15:0] thr_word, input logic [15:0] sr,
                             input logic [15:0] act, input logic [15:0] ovr,
                             input logic [15:0] win);
        for (int k = SPARE_INDEX; k < 2 ** INDEX_BITS; k++)
            set_register(INDEX_BITS'(k), 16'($urandom));
        set_register(REG_DELTA_THRESHOLD, thr_word);
        set_register(REG_LIMIT_SELF_REGULATING, sr);
        set_register(REG_LIMIT_ACTIVE, act);
        set_register(REG_LIMIT_OVERWHELMED, ovr);
        set_register(REG_WINDOW_LENGTH_MS, win);
        @(posedge clk);
        write_enable <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_sample(input logic [SAMPLE_BITS-1:0] raw, input bit hold = 1'b0);
        knob_item_t it;
        it.cmd = CMD_SAMPLE;
        it.raw = raw;
        it.hold = hold;
        pending_items.push_back(it);
        last_raw = raw;
    endtask

    task automatic queue_tick(input bit hold = 1'b0);
        knob_item_t it;
        it.cmd = CMD_TICK;
        it.raw = 12'($urandom);
        it.hold = hold;
        pending_items.push_back(it);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_raw();
        int unsigned r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            v = int'(last_raw) + int'($urandom_range(0, 60)) - 30;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            return 12'(v);
        end
        if (r < 6)
            return SEGMENT_ENDS[$urandom_range(0, 11)];
        return 12'($urandom);
    endfunction

    task automatic random_phase(input int p, input int count);
        int unsigned r, tick_pct;
        logic [15:0] thr_word, sr, act, ovr, win;
        r = $urandom_range(0, 9);
        thr_word = 16'($urandom);
        if (r == 0)
            thr_word[11:0] = '0;
        else if (r == 1)
            thr_word[11:0] = 12'hFFF;
        else
            thr_word[11:0] = 12'($urandom_range(0, 400));
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            sr = 16'($urandom);
            act = 16'($urandom);
            ovr = 16'($urandom);
        end
        else if (r == 1)
        begin
            sr = '0;
            act = 16'($urandom_range(0, 6));
            ovr = ALL_ONES_16;
        end
        else
        begin
            sr = 16'($urandom_range(0, 3));
            act = sr + 16'($urandom_range(0, 3));
            ovr = act + 16'($urandom_range(0, 4));
        end
        r = $urandom_range(0, 9);
        if (r == 0)
            win = '0;
        else if (r == 1)
            win = ALL_ONES_16;
        else if (r == 2)
            win = 16'($urandom);
        else
            win = 16'($urandom_range(1, 12));
        quiet = (p % 4 == 0);
        configure(thr_word, sr, act, ovr, win);
        tick_pct = $urandom_range(15, 60);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                queue_tick(i == count / 2);
            else
                queue_sample(pick_raw(), i == count / 2);
        end
        wait_drained();
    endtask

    // Full-scale swings in a long window: every sample after the first counts and the window stays open.
    task automatic swing_phase();
        quiet = 1'b1;
        configure(16'hF000, 16'd0, 16'd1, ALL_ONES_16, ALL_ONES_16);
        for (int i = 0; i < 16; i++)
            queue_sample((i % 2 == 0) ? 12'd0 : 12'd4095);
        for (int i = 0; i < 4; i++)
            queue_tick();
        queue_sample(12'd2047);
        wait_drained();
    endtask

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        quiet = 1'b0;

        foreach (SEGMENT_ENDS[i])
            queue_sample(SEGMENT_ENDS[i]);
        queue_tick();
        wait_drained();

        configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_sample(12'd2047);
        queue_sample(12'd2047);
        queue_tick();
        queue_sample(12'd4095);
        wait_drained();

        configure(16'd10, 16'd1, 16'd2, 16'd3, 16'd3);
        queue_sample(12'd100);
        queue_sample(12'd3000);
        queue_sample(12'd100);
        repeat (3) queue_tick();
        queue_sample(12'd3000);
        queue_sample(12'd3000);
        repeat (3) queue_tick();
        queue_sample(12'd3000);
        wait_drained();

        for (int p = 0; p < 12; p++)
            random_phase(p, 110);

        swing_phase();

        $display("Checked %0d samples and %0d ticks under %0d register settings.",
                 samples_sent, ticks_sent, settings_used);
        $display("%0d windows closed; levels reached (one bit per level) %b; %0d mismatches.",
                 windows_closed, levels_seen, fault_count);
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
